// ===== rtl/mkmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mkmc_pkg: shared types and constants for the keyword match counter
// Function codes, record kinds, field widths, sequencer states, saturating add.
// ----------------------------------------------------------------------------
package mkmc_pkg;

  // field widths of the input and result words
  localparam int FUNC_W   = 2;
  localparam int SLOT_IO_W = 4;
  localparam int POS_IO_W = 5;
  localparam int BYTE_W   = 8;
  localparam int LEN_IO_W = 6;
  localparam int RANK_W   = 8;
  localparam int COUNT_W  = 32;

  // input function codes
  localparam logic [FUNC_W-1:0] FUNC_KW_BYTE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_KW_LEN  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DATA    = 2'd2;

  // result record kinds
  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SCAN    = 6'b000010,
    ST_DRAIN   = 6'b000100,
    ST_RPT_RD  = 6'b001000,
    ST_RPT_CHK = 6'b010000,
    ST_TOTAL   = 6'b100000
  } state_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/multi_keyword_match_counter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Keyword byte/length words are taken while idle; a file byte holds in_stall until its scan ends.
// File bytes are taken one at a time, paced by the single window comparator
//   that checks one keyword slot per cycle (plus a 3-stage read/compare/update pipe).
// Report after the last byte: one record per nonzero slot plus the total, held off by out_stall.
// Reset: sync, active low; clears slot table, counts, total and sequencer.
//   Keyword bytes are undefined until written.
// ----------------------------------------------------------------------------
// multi_keyword_match_counter: streaming multi-keyword occurrence counter
// Loads a keyword table, counts every occurrence of each keyword in a byte
// stream and reports per-keyword counts and a saturated total on the last byte.
// ----------------------------------------------------------------------------
module multi_keyword_match_counter #(
  parameter int NUM_KEYWORDS = 16,
  parameter int MAX_LEN      = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // input words
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [mkmc_pkg::FUNC_W-1:0]        in_func,
  input  wire  [mkmc_pkg::SLOT_IO_W-1:0]     in_slot,
  input  wire  [mkmc_pkg::POS_IO_W-1:0]      in_position,
  input  wire  [mkmc_pkg::BYTE_W-1:0]        in_value,
  input  wire  [mkmc_pkg::LEN_IO_W-1:0]      in_length,
  input  wire  [mkmc_pkg::RANK_W-1:0]        in_rank,
  input  wire                                in_last_byte,
  // result words
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic                               out_kind,
  output logic [mkmc_pkg::SLOT_IO_W-1:0]     out_slot,
  output logic [mkmc_pkg::RANK_W-1:0]        out_rank,
  output logic [mkmc_pkg::COUNT_W-1:0]       out_count,
  output logic                               out_last
);
  import mkmc_pkg::*;

  localparam int SLOT_W = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
  localparam int POS_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int ROW_W  = MAX_LEN * BYTE_W;
  localparam int TAB_W  = LEN_W + RANK_W;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_KEYWORDS - 1);
  localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_LEN);

  // --------------------------------------------------------------------------
  // Storage
  // kw_mem  : one row per slot, all keyword bytes side by side, byte-lane writes
  // tab_mem : {rank, length} per slot; tab_vld_r marks written slots (else zero)
  // cnt_mem : match count per slot; cnt_vld_r marks counts since the last clear
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0]  kw_mem  [NUM_KEYWORDS];
  logic [TAB_W-1:0]  tab_mem [NUM_KEYWORDS];
  logic [COUNT_W-1:0] cnt_mem [NUM_KEYWORDS];
  logic [NUM_KEYWORDS-1:0] tab_vld_r;
  logic [NUM_KEYWORDS-1:0] cnt_vld_r;

  // window of the last MAX_LEN file bytes, newest at the top entry
  logic [BYTE_W-1:0] hist_r [MAX_LEN];
  logic [LEN_W-1:0]  seen_r;
  logic [COUNT_W-1:0] total_r;
  logic              last_pend_r;

  // sequencer
  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;

  // stage 1: registered reads at idx_r
  logic [ROW_W-1:0]   kw_rd_r;
  logic [TAB_W-1:0]   tab_rd_r;
  logic [COUNT_W-1:0] cnt_rd_r;
  logic               tab_vld_rd_r;
  logic               cnt_vld_rd_r;
  logic               p1_vld_r;
  logic [SLOT_W-1:0]  p1_slot_r;

  // stage 2: compare result
  logic               p2_vld_r;
  logic               p2_hit_r;
  logic [SLOT_W-1:0]  p2_slot_r;
  logic [COUNT_W-1:0] p2_cnt_r;

  // output register
  logic                 out_valid_r;
  logic                 out_kind_r;
  logic [SLOT_IO_W-1:0] out_slot_r;
  logic [RANK_W-1:0]    out_rank_r;
  logic [COUNT_W-1:0]   out_count_r;
  logic                 out_last_r;

  // --------------------------------------------------------------------------
  // Input handshake and table writes
  // --------------------------------------------------------------------------
  logic              in_accept;
  logic              slot_ok, pos_ok;
  logic              kw_we, tab_we, data_acc;
  logic [SLOT_W-1:0] wr_slot;
  logic [POS_W-1:0]  wr_pos;
  logic [LEN_W-1:0]  wr_len;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign slot_ok   = int'(in_slot) < NUM_KEYWORDS;
  assign pos_ok    = int'(in_position) < MAX_LEN;
  assign wr_slot   = SLOT_W'(in_slot);
  assign wr_pos    = POS_W'(in_position);
  // lengths above the row size are clipped to it
  assign wr_len    = (int'(in_length) > MAX_LEN) ? LEN_MAX : LEN_W'(in_length);
  assign kw_we     = in_accept && (in_func == FUNC_KW_BYTE) && slot_ok && pos_ok;
  assign tab_we    = in_accept && (in_func == FUNC_KW_LEN) && slot_ok;
  assign data_acc  = in_accept && (in_func == FUNC_DATA);

  always_ff @(posedge clk) begin
    if (kw_we) begin
      kw_mem[wr_slot][{wr_pos, 3'b000} +: BYTE_W] <= in_value;
    end
    kw_rd_r <= kw_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[wr_slot] <= {in_rank, wr_len};
    end
    tab_rd_r <= tab_mem[idx_r];
  end

  // --------------------------------------------------------------------------
  // Stage 2: align the window to the slot's length and compare byte lanes.
  // Keyword byte k pairs with the file byte (len-1-k) places back from newest.
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0]   len_cur;
  logic [RANK_W-1:0]  rank_cur;
  logic [COUNT_W-1:0] cnt_cur;
  logic [LEN_W-1:0]   shamt;
  logic [ROW_W-1:0]   hist_flat;
  logic [ROW_W-1:0]   win;
  logic               hit;

  assign len_cur  = tab_vld_rd_r ? tab_rd_r[LEN_W-1:0] : '0;
  assign rank_cur = tab_vld_rd_r ? tab_rd_r[LEN_W +: RANK_W] : '0;
  assign cnt_cur  = cnt_vld_rd_r ? cnt_rd_r : '0;
  assign shamt    = LEN_MAX - len_cur;

  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      hist_flat[i*BYTE_W +: BYTE_W] = hist_r[i];
    end
  end

  assign win = hist_flat >> {shamt, 3'b000};

  always_comb begin
    hit = (len_cur != '0) && (len_cur <= seen_r);
    for (int k = 0; k < MAX_LEN; k++) begin
      if ((LEN_W'(k) < len_cur) &&
          (kw_rd_r[k*BYTE_W +: BYTE_W] != win[k*BYTE_W +: BYTE_W])) begin
        hit = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Count memory: read at idx_r into stage 1, written back by stage 3
  // --------------------------------------------------------------------------
  logic cnt_we;
  assign cnt_we = p2_vld_r && p2_hit_r;

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[p2_slot_r] <= sat_inc(p2_cnt_r);
    end
    cnt_rd_r <= cnt_mem[idx_r];
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic out_free;
  logic rec_load;
  logic rec_total;
  logic clr_file;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    rec_load  = 1'b0;
    rec_total = 1'b0;
    clr_file  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (data_acc) begin
          state_nxt = ST_SCAN;
          idx_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        // wait for the last count write-back to land
        if (!p1_vld_r && !p2_vld_r) begin
          state_nxt = last_pend_r ? ST_RPT_RD : ST_IDLE;
        end
      end
      ST_RPT_RD: begin
        state_nxt = ST_RPT_CHK;
      end
      ST_RPT_CHK: begin
        // zero counts are skipped; nonzero ones wait for a free output slot
        if ((cnt_cur == '0) || out_free) begin
          rec_load = (cnt_cur != '0);
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_TOTAL;
            idx_nxt   = '0;
          end else begin
            state_nxt = ST_RPT_RD;
            idx_nxt   = idx_r + 1'b1;
          end
        end
      end
      ST_TOTAL: begin
        if (out_free) begin
          rec_load  = 1'b1;
          rec_total = 1'b1;
          clr_file  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        idx_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      tab_vld_r   <= '0;
      cnt_vld_r   <= '0;
      seen_r      <= '0;
      total_r     <= '0;
      last_pend_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      p1_vld_r <= (state_r == ST_SCAN);
      p2_vld_r <= p1_vld_r;
      if (tab_we) begin
        tab_vld_r[wr_slot] <= 1'b1;
      end
      if (clr_file) begin
        cnt_vld_r <= '0;
        total_r   <= '0;
        seen_r    <= '0;
      end else if (cnt_we) begin
        cnt_vld_r[p2_slot_r] <= 1'b1;
        total_r              <= sat_inc(total_r);
      end else if (data_acc && (seen_r != LEN_MAX)) begin
        seen_r <= seen_r + 1'b1;
      end
      if (data_acc) begin
        last_pend_r <= in_last_byte;
      end
    end
  end

  // payload pipeline registers
  always_ff @(posedge clk) begin
    tab_vld_rd_r <= tab_vld_r[idx_r];
    cnt_vld_rd_r <= cnt_vld_r[idx_r];
    p1_slot_r    <= idx_r;
    p2_hit_r     <= hit;
    p2_slot_r    <= p1_slot_r;
    p2_cnt_r     <= cnt_cur;
    if (data_acc) begin
      for (int i = 0; i < MAX_LEN - 1; i++) begin
        hist_r[i] <= hist_r[i+1];
      end
      hist_r[MAX_LEN-1] <= in_value;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: one record word, refilled as soon as it is taken
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rec_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_load) begin
      out_kind_r  <= rec_total ? KIND_TOTAL : KIND_COUNT;
      out_slot_r  <= rec_total ? '0 : SLOT_IO_W'(idx_r);
      out_rank_r  <= rec_total ? '0 : rank_cur;
      out_count_r <= rec_total ? total_r : cnt_cur;
      out_last_r  <= rec_total;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_slot  = out_slot_r;
  assign out_rank  = out_rank_r;
  assign out_count = out_count_r;
  assign out_last  = out_last_r;

`ifndef NO_ASSERTIONS
  // the compare pipe only runs while input is held off
  a_pipe_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_vld_r || p2_vld_r) |-> in_stall)
    else $error("compare pipe busy while input open");

  // emitting the total ends the report and clears the file state
  a_total_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TOTAL && out_free) |=>
      (out_valid && out_last && seen_r == '0 && total_r == '0 && cnt_vld_r == '0))
    else $error("total record without file clear");

  // per-keyword records carry a nonzero count and never end the report
  a_count_rec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_COUNT) |-> (out_count != '0 && !out_last))
    else $error("bad keyword count record");

  a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= LEN_MAX)
    else $error("byte counter past window size");
`endif

endmodule
`default_nettype wire
